>>> sv/byte_budget_clip_cache_unit_macros.svh
// Assertion macros for the clip cache directory.
// Expects signals named clk and rst in the scope of each use.
`ifndef BYTE_BUDGET_CLIP_CACHE_UNIT_MACROS_SVH
`define BYTE_BUDGET_CLIP_CACHE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BBCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BBCC_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBCC_ASSERT(lbl, prop, msg)
`define BBCC_ASSERT_NORST(lbl, prop, msg)
`endif
`endif

>>> sv/bbcc_pkg.sv
// Shared types and codes for the clip cache directory.
// No dependencies.
package bbcc_pkg;

  localparam int SLOTS_DEF    = 16;
  localparam int KEY_BITS_DEF = 32;

  localparam logic [1:0] OP_LOOKUP  = 2'd0;
  localparam logic [1:0] OP_INSERT  = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [1:0] MODE_AUTO     = 2'd0;
  localparam logic [1:0] MODE_RESIDENT = 2'd1;
  localparam logic [1:0] MODE_STREAM   = 2'd2;

  localparam logic [2:0] ST_HIT        = 3'd0;
  localparam logic [2:0] ST_MISS       = 3'd1;
  localparam logic [2:0] ST_INSERTED   = 3'd2;
  localparam logic [2:0] ST_NOT_CACHED = 3'd3;
  localparam logic [2:0] ST_RELEASED   = 3'd4;

  localparam logic [2:0] CM_NOP   = 3'd0;
  localparam logic [2:0] CM_BUMP  = 3'd1;
  localparam logic [2:0] CM_DROP  = 3'd2;
  localparam logic [2:0] CM_EVICT = 3'd3;
  localparam logic [2:0] CM_WRITE = 3'd4;

  localparam logic CFG_BUDGET = 1'b0;
  localparam logic CFG_THRESH = 1'b1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] key;
    logic [23:0] size;
    logic [31:0] stamp;
  } cmd_t;

  typedef struct packed {
    logic        hit_ok;
    logic        free_ok;
    logic        old_ok;
    logic [31:0] old_age;
    logic [23:0] old_size;
  } carry_t;

endpackage

>>> sv/bbcc_cell.sv
// One directory entry of the clip cache plus its stage of the scan chain.
// Depends on bbcc_pkg.
module bbcc_cell import bbcc_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF,
  parameter int IDX      = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  input  logic [$clog2(SLOTS)-1:0] cmd_idx,
  input  logic [31:0]              use_clock,
  input  carry_t                   carry_in,
  input  logic [$clog2(SLOTS)-1:0] hit_idx_in,
  input  logic [$clog2(SLOTS)-1:0] free_idx_in,
  input  logic [$clog2(SLOTS)-1:0] old_idx_in,
  output carry_t                   carry_out,
  output logic [$clog2(SLOTS)-1:0] hit_idx_out,
  output logic [$clog2(SLOTS)-1:0] free_idx_out,
  output logic [$clog2(SLOTS)-1:0] old_idx_out
);

  localparam int IW = $clog2(SLOTS);
  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam logic [IW-1:0] MY = IW'(IDX);

  logic          valid;
  logic [KW-1:0] key;
  logic [23:0]   size;
  logic [7:0]    refs;
  logic [31:0]   stamp;

  logic          sel;
  logic [31:0]   age;
  logic          match;
  logic          cand_old;

  assign sel      = (cmd_idx == MY);
  assign age      = use_clock - stamp;
  assign match    = valid && (key == cmd.key[KW-1:0]);
  assign cand_old = valid && (refs == 8'd0) &&
                    (!carry_in.old_ok || (age > carry_in.old_age));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sel) begin
      if (cmd.kind == CM_EVICT) begin
        valid <= 1'b0;
      end else if (cmd.kind == CM_WRITE) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      case (cmd.kind)
        CM_BUMP: begin
          if (refs != 8'hFF) begin
            refs <= refs + 8'd1;
          end
          stamp <= cmd.stamp;
        end
        CM_DROP: begin
          if (valid && (refs != 8'd0)) begin
            refs <= refs - 8'd1;
          end
        end
        CM_WRITE: begin
          key   <= cmd.key[KW-1:0];
          size  <= cmd.size;
          refs  <= 8'd1;
          stamp <= cmd.stamp;
        end
        default: begin
        end
      endcase
    end
  end

  // scan stage: first hit, first empty slot, oldest unpinned entry
  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out <= '0;
    end else begin
      carry_out.hit_ok  <= carry_in.hit_ok || match;
      carry_out.free_ok <= carry_in.free_ok || !valid;
      if (cand_old) begin
        carry_out.old_ok   <= 1'b1;
        carry_out.old_age  <= age;
        carry_out.old_size <= size;
      end else begin
        carry_out.old_ok   <= carry_in.old_ok;
        carry_out.old_age  <= carry_in.old_age;
        carry_out.old_size <= carry_in.old_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_out  <= (!carry_in.hit_ok && match) ? MY : hit_idx_in;
    free_idx_out <= (!carry_in.free_ok && !valid) ? MY : free_idx_in;
    old_idx_out  <= cand_old ? MY : old_idx_in;
  end

endmodule

>>> sv/bbcc_ctrl.sv
// Sequencer of the clip cache: handshakes, config registers, byte count and
// stamp clock; drives commands into the cell chain. Depends on bbcc_pkg.
`include "byte_budget_clip_cache_unit_macros.svh"
module bbcc_ctrl import bbcc_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic [1:0]               operation,
  input  logic [31:0]              clip_key,
  input  logic [23:0]              clip_bytes,
  input  logic [1:0]               load_mode,
  input  logic [3:0]               release_slot,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic [2:0]               status,
  output logic [3:0]               slot,
  output logic [4:0]               evicted_count,
  output logic [23:0]              cached_total,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [23:0]              cfg_data,
  output cmd_t                     cmd,
  output logic [$clog2(SLOTS)-1:0] cmd_idx,
  output logic [31:0]              use_clock,
  input  carry_t                   carry,
  input  logic [$clog2(SLOTS)-1:0] hit_idx,
  input  logic [$clog2(SLOTS)-1:0] free_idx,
  input  logic [$clog2(SLOTS)-1:0] old_idx
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 2);
  localparam logic [CW-1:0] SCAN_END = CW'(SLOTS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]    state;
  logic [CW-1:0] cnt;
  logic [1:0]    op;
  logic [23:0]   bytes;
  logic [23:0]   budget;
  logic [23:0]   thresh;
  logic [23:0]   used;
  logic [4:0]    evcnt;
  logic [2:0]    res_status;
  logic [IW-1:0] res_slot;

  logic          fit;
  logic          cacheable;
  logic [4:0]    evcnt_next;
  logic [31:0]   clock_next;
  logic [IW+3:0] rpad;
  logic          rel_ok;
  logic [IW+3:0] spad;
  logic [24:0]   need;
  logic [2:0]    kind_next;

  assign need       = {1'b0, used} + {1'b0, bytes};
  assign fit        = need <= {1'b0, budget};
  assign cacheable  = (load_mode == MODE_RESIDENT) ? (clip_bytes <= budget) :
                      (load_mode == MODE_AUTO) ? (clip_bytes <= thresh) : 1'b0;
  assign evcnt_next = (evcnt == 5'd31) ? evcnt : evcnt + 5'd1;
  assign clock_next = use_clock + 32'd1;
  assign rpad       = {{IW{1'b0}}, release_slot};
  assign rel_ok     = rpad < (IW + 4)'(SLOTS);
  assign spad       = {4'b0000, res_slot};
  assign req_stall  = (state != S_IDLE);

  always_comb begin
    kind_next = CM_NOP;
    if (state == S_IDLE) begin
      if (req_valid && (operation == OP_RELEASE) && rel_ok) begin
        kind_next = CM_DROP;
      end
    end else if ((state == S_SCAN) && (cnt == SCAN_END)) begin
      if (op == OP_LOOKUP) begin
        if (carry.hit_ok) begin
          kind_next = CM_BUMP;
        end
      end else if (!fit) begin
        if (carry.old_ok) begin
          kind_next = CM_EVICT;
        end
      end else if (carry.free_ok || carry.old_ok) begin
        kind_next = CM_WRITE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= 24'd1048576;
      thresh <= 24'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUDGET: budget <= cfg_data;
        CFG_THRESH: thresh <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      used      <= '0;
      use_clock <= '0;
      rsp_valid <= 1'b0;
      cmd.kind  <= CM_NOP;
    end else begin
      cmd.kind <= kind_next;
      if (state == S_OUT && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op       <= operation;
            bytes    <= clip_bytes;
            cmd.key  <= clip_key;
            evcnt    <= '0;
            res_slot <= '0;
            cnt      <= '0;
            unique case (operation)
              OP_LOOKUP: begin
                if (load_mode != MODE_STREAM) begin
                  state <= S_SCAN;
                end else begin
                  res_status <= ST_MISS;
                  state      <= S_OUT;
                end
              end
              OP_INSERT: begin
                if (cacheable) begin
                  state <= S_SCAN;
                end else begin
                  res_status <= ST_NOT_CACHED;
                  state      <= S_OUT;
                end
              end
              OP_RELEASE: begin
                if (rel_ok) begin
                  cmd_idx <= rpad[IW-1:0];
                end
                res_status <= ST_RELEASED;
                state      <= S_OUT;
              end
              default: begin
                res_status <= ST_MISS;
                state      <= S_OUT;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (cnt != SCAN_END) begin
            cnt <= cnt + 1'b1;
          end else if (op == OP_LOOKUP) begin
            if (carry.hit_ok) begin
              cmd_idx    <= hit_idx;
              cmd.stamp  <= clock_next;
              use_clock  <= clock_next;
              res_status <= ST_HIT;
              res_slot   <= hit_idx;
            end else begin
              res_status <= ST_MISS;
            end
            state <= S_OUT;
          end else if (!fit) begin
            if (carry.old_ok) begin
              cmd_idx <= old_idx;
              used    <= used - carry.old_size;
              evcnt   <= evcnt_next;
              cnt     <= '0;
            end else begin
              res_status <= ST_NOT_CACHED;
              state      <= S_OUT;
            end
          end else begin
            state <= S_OUT;
            if (carry.free_ok || carry.old_ok) begin
              cmd.size   <= bytes;
              cmd.stamp  <= clock_next;
              use_clock  <= clock_next;
              res_status <= ST_INSERTED;
              if (carry.free_ok) begin
                cmd_idx  <= free_idx;
                res_slot <= free_idx;
                used     <= used + bytes;
              end else begin
                // all slots full: reuse the oldest unpinned one
                cmd_idx  <= old_idx;
                res_slot <= old_idx;
                used     <= used - carry.old_size + bytes;
                evcnt    <= evcnt_next;
              end
            end else begin
              res_status <= ST_NOT_CACHED;
            end
          end
        end
        S_OUT: begin
          if (!rsp_valid || !rsp_stall) begin
            status        <= res_status;
            slot          <= spad[3:0];
            evicted_count <= evcnt;
            cached_total  <= used;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BBCC_ASSERT(a_accept_leaves_idle, (req_valid && !req_stall) |=> (state != S_IDLE), "accepted item did not start")
  `BBCC_ASSERT(a_cmd_single, (cmd.kind != CM_NOP) |=> (cmd.kind == CM_NOP), "command held past one cycle")
  `BBCC_ASSERT(a_scan_bound, (state == S_SCAN) |-> (cnt <= SCAN_END), "scan counter overran")
  `BBCC_ASSERT(a_result_out, (state == S_OUT && (!rsp_valid || !rsp_stall)) |=> (rsp_valid && state == S_IDLE), "result not delivered")
  `BBCC_ASSERT_NORST(a_reset_idle, rst |=> (state == S_IDLE && !rsp_valid), "reset left block busy")

endmodule

>>> sv/byte_budget_clip_cache_unit.sv
// Top level of the byte-budgeted clip cache directory: sequencer plus a row of
// entry cells forming the scan chain. Depends on bbcc_pkg, bbcc_ctrl, bbcc_cell.
//
// Usage:
//   Request channel (req_valid/req_stall) carries one item: operation, clip_key,
//   clip_bytes, load_mode, release_slot. It is taken when req_valid is high and
//   req_stall low. Response channel (rsp_valid/rsp_stall) returns one item per
//   request: status, slot, evicted_count, cached_total, held in an output
//   register until taken.
//   Steps from the accepting edge to the result register load: a release, a
//   streamed lookup, an uncacheable insert or an unused operation go straight to
//   the output state; a lookup first makes one scan pass down the cell chain; a
//   cacheable insert scans once and rescans after each entry evicted to make the
//   bytes fit. One item is in work at a time; the next is taken the cycle after
//   the result is loaded, even while rsp_stall holds it there. A new result
//   waits behind it and the input stalls.
//   Config writes (cfg_we, cfg_index, cfg_data) take effect at once and are
//   meant for idle periods.
//   Reset (rst, synchronous) clears all entry valid bits, the byte count and
//   the stamp clock, and restores the default budget and threshold.
module byte_budget_clip_cache_unit import bbcc_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  operation,
  input  logic [31:0] clip_key,
  input  logic [23:0] clip_bytes,
  input  logic [1:0]  load_mode,
  input  logic [3:0]  release_slot,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [2:0]  status,
  output logic [3:0]  slot,
  output logic [4:0]  evicted_count,
  output logic [23:0] cached_total,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int IW = $clog2(SLOTS);

  cmd_t          cmd;
  logic [IW-1:0] cmd_idx;
  logic [31:0]   use_clock;
  carry_t        chain    [SLOTS+1];
  logic [IW-1:0] hit_idx  [SLOTS+1];
  logic [IW-1:0] free_idx [SLOTS+1];
  logic [IW-1:0] old_idx  [SLOTS+1];

  assign chain[0]    = '0;
  assign hit_idx[0]  = '0;
  assign free_idx[0] = '0;
  assign old_idx[0]  = '0;

  bbcc_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .operation     (operation),
    .clip_key      (clip_key),
    .clip_bytes    (clip_bytes),
    .load_mode     (load_mode),
    .release_slot  (release_slot),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .slot          (slot),
    .evicted_count (evicted_count),
    .cached_total  (cached_total),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .cmd_idx       (cmd_idx),
    .use_clock     (use_clock),
    .carry         (chain[SLOTS]),
    .hit_idx       (hit_idx[SLOTS]),
    .free_idx      (free_idx[SLOTS]),
    .old_idx       (old_idx[SLOTS])
  );

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    bbcc_cell #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS),
      .IDX      (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .cmd          (cmd),
      .cmd_idx      (cmd_idx),
      .use_clock    (use_clock),
      .carry_in     (chain[i]),
      .hit_idx_in   (hit_idx[i]),
      .free_idx_in  (free_idx[i]),
      .old_idx_in   (old_idx[i]),
      .carry_out    (chain[i+1]),
      .hit_idx_out  (hit_idx[i+1]),
      .free_idx_out (free_idx[i+1]),
      .old_idx_out  (old_idx[i+1])
    );
  end

endmodule

>>> sim/testbench.sv
// Self-checking bench for byte_budget_clip_cache_unit: random and directed clip requests,
// a cycle-free model of the slot directory predicting every response item.
// Depends on bbcc_pkg and the RTL of byte_budget_clip_cache_unit.
`timescale 1ns / 1ps

module testbench;
  import bbcc_pkg::*;

  localparam int CACHE_SLOTS = SLOTS_DEF;
  localparam int POOL_KEYS   = 24;
  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 500;
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
    logic [23:0] bytes;
    logic [1:0]  mode;
    logic [3:0]  rslot;
  } clip_request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [4:0]  evicted;
    logic [23:0] total;
  } cache_answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  operation = '0;
  logic [31:0] clip_key = '0;
  logic [23:0] clip_bytes = '0;
  logic [1:0]  load_mode = '0;
  logic [3:0]  release_slot = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [2:0]  status;
  logic [3:0]  slot;
  logic [4:0]  evicted_count;
  logic [23:0] cached_total;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [23:0] cfg_data = '0;

  // directory model
  logic        line_valid [CACHE_SLOTS] = '{default: 1'b0};
  logic [31:0] line_key   [CACHE_SLOTS] = '{default: '0};
  logic [23:0] line_size  [CACHE_SLOTS] = '{default: '0};
  logic [7:0]  line_refs  [CACHE_SLOTS] = '{default: '0};
  logic [31:0] line_stamp [CACHE_SLOTS] = '{default: '0};
  logic [23:0] bytes_held      = '0;
  logic [31:0] stamp_clock     = '0;
  logic [23:0] budget_limit    = 24'd1048576;
  logic [23:0] threshold_limit = 24'd65536;

  clip_request_t requests_waiting[$];
  cache_answer_t answers_due[$];
  logic [31:0]   key_pool [POOL_KEYS];

  int send_gap = 0;
  int send_burst = 0;
  int stall_left = 0;
  int calm_left = 0;
  int hold_left = 0;
  int next_hold_at = 150;
  int answers_seen = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;

  byte_budget_clip_cache_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .operation(operation), .clip_key(clip_key), .clip_bytes(clip_bytes),
    .load_mode(load_mode), .release_slot(release_slot),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .slot(slot), .evicted_count(evicted_count),
    .cached_total(cached_total),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int oldest_unpinned();
    int best;
    int i;
    logic [31:0] best_age;
    logic [31:0] age;
    best = -1;
    best_age = '0;
    for (i = 0; i < CACHE_SLOTS; i++) begin
      if (line_valid[i] && line_refs[i] == 8'd0) begin
        age = stamp_clock - line_stamp[i];
        if (best < 0 || age > best_age) begin
          best = i;
          best_age = age;
        end
      end
    end
    return best;
  endfunction

  function automatic void drop_line(int n);
    bytes_held = bytes_held - line_size[n];
    line_valid[n] = 1'b0;
  endfunction

  function automatic cache_answer_t predict_answer(clip_request_t r);
    cache_answer_t a;
    int i;
    int victim;
    int free_slot;
    int evicted;
    logic cacheable;
    a.status = ST_MISS;
    a.slot = '0;
    evicted = 0;
    case (r.op)
      OP_LOOKUP: begin
        if (r.mode != MODE_STREAM) begin
          for (i = 0; i < CACHE_SLOTS; i++) begin
            if (line_valid[i] && line_key[i] == r.key) begin
              if (line_refs[i] != 8'hFF) line_refs[i]++;
              stamp_clock++;
              line_stamp[i] = stamp_clock;
              a.status = ST_HIT;
              a.slot = 4'(i);
              break;
            end
          end
        end
      end
      OP_INSERT: begin
        case (r.mode)
          MODE_RESIDENT: cacheable = r.bytes <= budget_limit;
          MODE_AUTO:     cacheable = r.bytes <= threshold_limit;
          default:       cacheable = 1'b0;
        endcase
        a.status = ST_NOT_CACHED;
        if (cacheable) begin
          victim = 0;
          while (victim >= 0 && {1'b0, bytes_held} + r.bytes > budget_limit) begin
            victim = oldest_unpinned();
            if (victim >= 0) begin
              drop_line(victim);
              evicted++;
            end
          end
          if ({1'b0, bytes_held} + r.bytes <= budget_limit) begin
            free_slot = -1;
            for (i = CACHE_SLOTS - 1; i >= 0; i--) begin
              if (!line_valid[i]) free_slot = i;
            end
            if (free_slot < 0) begin
              free_slot = oldest_unpinned();
              if (free_slot >= 0) begin
                drop_line(free_slot);
                evicted++;
              end
            end
            if (free_slot >= 0) begin
              line_valid[free_slot] = 1'b1;
              line_key[free_slot] = r.key;
              line_size[free_slot] = r.bytes;
              line_refs[free_slot] = 8'd1;
              stamp_clock++;
              line_stamp[free_slot] = stamp_clock;
              bytes_held = bytes_held + r.bytes;
              a.status = ST_INSERTED;
              a.slot = 4'(free_slot);
            end
          end
        end
      end
      OP_RELEASE: begin
        a.status = ST_RELEASED;
        if (line_valid[r.rslot] && line_refs[r.rslot] != 8'd0) line_refs[r.rslot]--;
      end
      default: ;
    endcase
    a.evicted = (evicted > 31) ? 5'd31 : 5'(evicted);
    a.total = bytes_held;
    return a;
  endfunction

  function automatic clip_request_t make_request(logic [1:0] op, logic [31:0] key,
                                                 logic [23:0] bytes, logic [1:0] mode,
                                                 logic [3:0] rslot);
    clip_request_t r;
    r.op = op;
    r.key = key;
    r.bytes = bytes;
    r.mode = mode;
    r.rslot = rslot;
    return r;
  endfunction

  function automatic void add_request(clip_request_t r);
    requests_waiting.insert(requests_waiting.size(), r);
  endfunction

  function automatic clip_request_t random_request(int unsigned size_cap);
    clip_request_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) r.op = OP_INSERT;
    else if (pick < 55) r.op = OP_LOOKUP;
    else if (pick < 95) r.op = OP_RELEASE;
    else r.op = OP_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 45) r.mode = MODE_AUTO;
    else if (pick < 85) r.mode = MODE_RESIDENT;
    else if (pick < 95) r.mode = MODE_STREAM;
    else r.mode = MODE_UNUSED;
    r.key = ($urandom_range(0, 9) != 0) ? key_pool[$urandom_range(0, POOL_KEYS - 1)]
                                       : $urandom;
    r.bytes = ($urandom_range(0, 99) < 85) ? 24'($urandom_range(0, size_cap))
                                           : 24'($urandom);
    r.rslot = 4'($urandom_range(0, 15));
    return r;
  endfunction

  function automatic int pick_send_gap();
    int unsigned pick;
    if (send_burst > 0) begin
      send_burst--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_burst = $urandom_range(20, 60);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("mismatch at result %0d: %s got %0d expected %0d",
               answers_seen, what, got, want);
  endtask

  always @(posedge clk) begin : drive_requests
    logic next_valid;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      next_valid = req_valid;
      if (req_valid && !req_stall) begin
        answers_due.insert(answers_due.size(), predict_answer(requests_waiting.pop_front()));
        next_valid = 1'b0;
        send_gap = pick_send_gap();
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (requests_waiting.size() != 0) begin
          operation <= requests_waiting[0].op;
          clip_key <= requests_waiting[0].key;
          clip_bytes <= requests_waiting[0].bytes;
          load_mode <= requests_waiting[0].mode;
          release_slot <= requests_waiting[0].rslot;
          next_valid = 1'b1;
        end
      end
      req_valid <= next_valid;
    end
  end

  always @(posedge clk) begin : check_answers
    cache_answer_t want;
    int unsigned pick;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        answers_seen++;
        if (answers_due.size() == 0) begin
          report_mismatch("result with nothing outstanding, status", status, 0);
        end else begin
          want = answers_due.pop_front();
          if (status !== want.status) report_mismatch("status", status, want.status);
          if (slot !== want.slot) report_mismatch("slot", slot, want.slot);
          if (evicted_count !== want.evicted)
            report_mismatch("evicted_count", evicted_count, want.evicted);
          if (cached_total !== want.total)
            report_mismatch("cached_total", cached_total, want.total);
        end
      end
      // long hold-off so the block fills and stalls its input
      if (answers_seen >= next_hold_at) begin
        hold_left = HOLD_CYCLES;
        next_hold_at += 450;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else if (calm_left > 0) begin
        calm_left--;
        rsp_stall <= 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) calm_left = $urandom_range(1, (pick < 6) ? 120 : 15);
        else if (pick < 93) stall_left = $urandom_range(1, 4);
        else stall_left = $urandom_range(20, 80);
        rsp_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("byte_budget_clip_cache_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (requests_waiting.size() != 0 || answers_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(logic idx, logic [23:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BUDGET) budget_limit = value;
    else threshold_limit = value;
  endtask

  task automatic configure(logic [23:0] budget, logic [23:0] thresh);
    wait_drained();
    repeat (20) @(posedge clk);
    write_register(CFG_BUDGET, budget);
    write_register(CFG_THRESH, thresh);
    @(negedge clk);
  endtask

  task automatic queue_random(int count, int unsigned size_cap);
    int n;
    for (n = 0; n < count; n++) add_request(random_request(size_cap));
  endtask

  initial begin : stimulus
    int n;
    logic [31:0] hot_key;
    for (n = 0; n < POOL_KEYS; n++) key_pool[n] = $urandom;
    hot_key = $urandom;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default budget 1 MiB, auto threshold 64 KiB
    add_request(make_request(OP_LOOKUP, 32'h0, 24'd0, MODE_AUTO, 4'd0));
    add_request(make_request(OP_INSERT, 32'hA000_0001, 24'd65536,
                             MODE_AUTO, 4'd0));
    add_request(make_request(OP_INSERT, 32'hB000_0002, 24'd65537,
                             MODE_AUTO, 4'd0));
    add_request(make_request(OP_INSERT, 32'hC000_0003, 24'd983040,
                             MODE_RESIDENT, 4'd0));
    add_request(make_request(OP_INSERT, 32'hF000_0004, 24'd16,
                             MODE_STREAM, 4'd0));
    add_request(make_request(OP_INSERT, 32'hF000_0004, 24'd16,
                             MODE_UNUSED, 4'd0));
    add_request(make_request(OP_LOOKUP, 32'hA000_0001, 24'd0, MODE_AUTO, 4'd0));
    add_request(make_request(OP_LOOKUP, 32'hA000_0001, 24'd0,
                             MODE_STREAM, 4'd0));
    add_request(make_request(OP_LOOKUP, 32'hA000_0001, 24'd0,
                             MODE_UNUSED, 4'd0));
    add_request(make_request(OP_UNUSED, 32'hA000_0001, 24'd0, MODE_AUTO, 4'd0));
    for (n = 0; n < 4; n++)
      add_request(make_request(OP_RELEASE, 32'h0, 24'd0, MODE_AUTO, 4'd0));
    add_request(make_request(OP_RELEASE, 32'h0, 24'd0, MODE_AUTO, 4'd15));
    // evicts the unpinned entry, then a refusal with everything pinned
    add_request(make_request(OP_INSERT, 32'hD000_0005, 24'd1,
                             MODE_RESIDENT, 4'd0));
    add_request(make_request(OP_INSERT, 32'hE000_0006, 24'd1048576,
                             MODE_RESIDENT, 4'd0));
    add_request(make_request(OP_RELEASE, 32'h0, 24'd0, MODE_AUTO, 4'd1));
    add_request(make_request(OP_RELEASE, 32'h0, 24'd0, MODE_AUTO, 4'd0));
    add_request(make_request(OP_INSERT, 32'hE000_0006, 24'd1048576,
                             MODE_RESIDENT, 4'd0));
    // duplicate key, lookup must find the lower slot
    add_request(make_request(OP_INSERT, 32'hE000_0006, 24'd0, MODE_AUTO, 4'd0));
    add_request(make_request(OP_LOOKUP, 32'hE000_0006, 24'd0, MODE_AUTO, 4'd0));
    add_request(make_request(OP_INSERT, 32'hFFFF_FFFF, 24'hFF_FFFF,
                             MODE_RESIDENT, 4'd15));

    configure(24'd4096, 24'd1024);
    // unpin the leftovers, then drive one entry's count into saturation
    add_request(make_request(OP_RELEASE, 32'h0, 24'd0, MODE_AUTO, 4'd0));
    add_request(make_request(OP_RELEASE, 32'h0, 24'd0, MODE_AUTO, 4'd0));
    add_request(make_request(OP_RELEASE, 32'h0, 24'd0, MODE_AUTO, 4'd1));
    add_request(make_request(OP_INSERT, hot_key, 24'd1, MODE_AUTO, 4'd0));
    for (n = 0; n < 258; n++)
      add_request(make_request(OP_LOOKUP, hot_key, 24'($urandom),
                               (n % 3 == 2) ? MODE_UNUSED : 2'(n % 3),
                               4'($urandom_range(0, 15))));
    queue_random(180, 1200);

    // budget below what is held: nothing fits until unpinned entries go
    configure(24'd0, 24'd0);
    queue_random(60, 2);

    configure(24'hFF_FFFF, 24'hFF_FFFF);
    queue_random(170, 24'h3_FFFF);

    configure(24'd300000, 24'd0);
    queue_random(150, 80000);

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("byte_budget_clip_cache_unit regression: pass");
    end else begin
      $display("byte_budget_clip_cache_unit regression: fail");
    end
    $finish;
  end

endmodule

>>> byte_budget_clip_cache_unit.f
+incdir+sv
sv/bbcc_pkg.sv
sv/bbcc_cell.sv
sv/bbcc_ctrl.sv
sv/byte_budget_clip_cache_unit.sv
sim/testbench.sv
